// ----- rtl/dlte_pkg.sv -----
// ----------------------------------------------------------------------------
// dlte_pkg
// Types, codes and constants shared by the line table encoder modules.
// ----------------------------------------------------------------------------
package dlte_pkg;

  // marker bytes of the line table stream
  localparam logic [7:0] MarkFile   = 8'd253;
  localparam logic [7:0] MarkLine   = 8'd254;
  localparam logic [7:0] MarkOffset = 8'd255;

  // short form limits: line step below 126, offset advance below 129
  localparam logic [15:0] LineStepLimit   = 16'd126;
  localparam logic [7:0]  LineStepBias    = 8'd127;
  localparam logic [23:0] OffsetStepLimit = 24'd129;

  // default depth of the command queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // event kind codes
  localparam logic FuncFile = 1'b0;
  localparam logic FuncLine = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] value;
    logic [23:0] code_offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ADV_NONE,
    ADV_SHORT,
    ADV_LONG
  } adv_kind_e;

  typedef enum logic [1:0] {
    EVT_FILE,
    EVT_LINE_SHORT,
    EVT_LINE_LONG
  } evt_kind_e;

  // one classified event, ready to be serialized
  typedef struct packed {
    adv_kind_e   adv;
    logic [7:0]  adv_byte;
    logic [23:0] offset;
    evt_kind_e   evt;
    logic [15:0] value;
    logic [7:0]  line_byte;
  } cmd_t;

endpackage

// ----- rtl/debug_line_table_encoder_top.sv -----
// ----------------------------------------------------------------------------
// debug_line_table_encoder_top
// Turns file and line change events into a compact line table byte stream.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ------------------------------
//  in        in         in_valid_i/in_stall_o   func, value, code_offset
//  out       out        out_valid_o/out_stall_i out_byte, last
//
//  an event is accepted while the command queue has room; the front
//  classifies it and, for a changed file or line, updates it and the offset
//  on the spot; each event emits 0 to 7 bytes, one per cycle while
//  out_stall_i is low, through the single-byte output register;
//  back-to-back commands run with no gap
//  reset clears stored file, line and offset to zero, empties the queue and
//  drops the output register; no clearing pass
//  out_stall_i freezes the serializer; once the queue fills, in_stall_o rises
//
module debug_line_table_encoder_top #(
  parameter int unsigned QueueDepth = dlte_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dlte_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dlte_pkg::out_item_t out_data_o
);
  import dlte_pkg::*;

  // command path between front, queue and serializer
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_pop_cmd;

  // front: accepts transactions, drops unchanged events, builds commands
  dlte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_push_cmd)
  );

  // queue decouples the accept side from the byte side
  dlte_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_pop_cmd)
  );

  // back: serializes each command into output transactions
  dlte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/dlte_front.sv -----
// ----------------------------------------------------------------------------
// dlte_front
// Accepts events, compares against the stored file, line and offset, and
// turns each changing event into a command for the serializer.
// ----------------------------------------------------------------------------
module dlte_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dlte_pkg::in_item_t in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output dlte_pkg::cmd_t     q_cmd_o
);
  import dlte_pkg::*;

  logic [23:0] prev_offset_q, prev_offset_d;
  logic [7:0]  cur_file_q, cur_file_d;
  logic [15:0] cur_line_q, cur_line_d;

  logic        accept;
  logic        changed;
  logic [24:0] off_diff;
  logic        off_short;
  logic [16:0] line_diff;
  logic        line_short;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign off_diff  = {1'b0, in_data_i.code_offset} - {1'b0, prev_offset_q};
  assign off_short = !off_diff[24] && (off_diff[23:0] != 24'd0) &&
                     (off_diff[23:0] < OffsetStepLimit);

  assign line_diff  = {1'b0, in_data_i.value} - {1'b0, cur_line_q};
  assign line_short = !line_diff[16] && (line_diff[15:0] != 16'd0) &&
                      (line_diff[15:0] < LineStepLimit);

  always_comb begin
    changed = (in_data_i.func == FuncFile) ? (in_data_i.value[7:0] != cur_file_q)
                                           : (in_data_i.value != cur_line_q);

    q_cmd_o.offset    = in_data_i.code_offset;
    q_cmd_o.value     = in_data_i.value;
    q_cmd_o.adv_byte  = off_diff[7:0] - 8'd1;
    q_cmd_o.line_byte = line_diff[7:0] + LineStepBias;

    if (in_data_i.code_offset == prev_offset_q) begin
      q_cmd_o.adv = ADV_NONE;
    end else if (off_short) begin
      q_cmd_o.adv = ADV_SHORT;
    end else begin
      q_cmd_o.adv = ADV_LONG;
    end

    if (in_data_i.func == FuncFile) begin
      q_cmd_o.evt = EVT_FILE;
    end else if (line_short) begin
      q_cmd_o.evt = EVT_LINE_SHORT;
    end else begin
      q_cmd_o.evt = EVT_LINE_LONG;
    end

    q_push_o      = accept && changed;
    prev_offset_d = prev_offset_q;
    cur_file_d    = cur_file_q;
    cur_line_d    = cur_line_q;
    if (q_push_o) begin
      prev_offset_d = in_data_i.code_offset;
      if (in_data_i.func == FuncFile) begin
        cur_file_d = in_data_i.value[7:0];
      end else begin
        cur_line_d = in_data_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_offset_q <= '0;
      cur_file_q    <= '0;
      cur_line_q    <= '0;
    end else begin
      prev_offset_q <= prev_offset_d;
      cur_file_q    <= cur_file_d;
      cur_line_q    <= cur_line_d;
    end
  end

endmodule

// ----- rtl/dlte_fifo.sv -----
// ----------------------------------------------------------------------------
// dlte_fifo
// Short command queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module dlte_fifo #(
  parameter int unsigned Depth = dlte_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dlte_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dlte_pkg::cmd_t pop_cmd_o
);
  import dlte_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("command queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty command queue");

endmodule

// ----- rtl/dlte_back.sv -----
// ----------------------------------------------------------------------------
// dlte_back
// Serializer: walks each command byte by byte into the output register.
// ----------------------------------------------------------------------------
module dlte_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  dlte_pkg::cmd_t      q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dlte_pkg::out_item_t out_data_o
);
  import dlte_pkg::*;

  typedef enum logic [3:0] {
    PH_ADV_SHORT,
    PH_ADV_MARK,
    PH_ADV_B0,
    PH_ADV_B1,
    PH_ADV_B2,
    PH_EVT_MARK,
    PH_EVT_B0,
    PH_EVT_B1,
    PH_EVT_SHORT
  } phase_e;

  logic      busy_q, busy_d;
  phase_e    phase_q, phase_d;
  cmd_t      cmd_q, cmd_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic      advance;
  logic      cur_last;
  logic [7:0] cur_byte;
  phase_e    cur_next;

  function automatic phase_e evt_first(input cmd_t c);
    evt_first = (c.evt == EVT_LINE_SHORT) ? PH_EVT_SHORT : PH_EVT_MARK;
  endfunction

  function automatic phase_e cmd_first(input cmd_t c);
    case (c.adv)
      ADV_SHORT: cmd_first = PH_ADV_SHORT;
      ADV_LONG:  cmd_first = PH_ADV_MARK;
      default:   cmd_first = evt_first(c);
    endcase
  endfunction

  // byte, last flag and follow-on phase for the current step
  always_comb begin
    cur_byte = '0;
    cur_last = 1'b0;
    cur_next = phase_q;
    case (phase_q)
      PH_ADV_SHORT: begin
        cur_byte = cmd_q.adv_byte;
        cur_next = evt_first(cmd_q);
      end
      PH_ADV_MARK: begin
        cur_byte = MarkOffset;
        cur_next = PH_ADV_B0;
      end
      PH_ADV_B0: begin
        cur_byte = cmd_q.offset[7:0];
        cur_next = PH_ADV_B1;
      end
      PH_ADV_B1: begin
        cur_byte = cmd_q.offset[15:8];
        cur_next = PH_ADV_B2;
      end
      PH_ADV_B2: begin
        cur_byte = cmd_q.offset[23:16];
        cur_next = evt_first(cmd_q);
      end
      PH_EVT_MARK: begin
        cur_byte = (cmd_q.evt == EVT_FILE) ? MarkFile : MarkLine;
        cur_next = PH_EVT_B0;
      end
      PH_EVT_B0: begin
        cur_byte = cmd_q.value[7:0];
        cur_last = (cmd_q.evt == EVT_FILE);
        cur_next = PH_EVT_B1;
      end
      PH_EVT_B1: begin
        cur_byte = cmd_q.value[15:8];
        cur_last = 1'b1;
      end
      PH_EVT_SHORT: begin
        cur_byte = cmd_q.line_byte;
        cur_last = 1'b1;
      end
      default: begin
        cur_last = 1'b1;
      end
    endcase
  end

  assign advance = busy_q && (!out_valid_q || !out_stall_i);
  assign q_pop_o = q_valid_i && (!busy_q || (advance && cur_last));

  always_comb begin
    busy_d      = busy_q;
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (advance) begin
      out_valid_d    = 1'b1;
      out_d.out_byte = cur_byte;
      out_d.last     = cur_last;
      phase_d        = cur_next;
      if (cur_last) begin
        busy_d = 1'b0;
      end
    end

    if (q_pop_o) begin
      busy_d  = 1'b1;
      cmd_d   = q_cmd_i;
      phase_d = cmd_first(q_cmd_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_EVT_MARK;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      out_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_b1_long_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && phase_q == PH_EVT_B1) |-> (cmd_q.evt == EVT_LINE_LONG))
    else $error("high line byte for a non-long line command");

  a_short_adv_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && phase_q == PH_ADV_SHORT) |-> (cmd_q.adv == ADV_SHORT))
    else $error("short advance step for a command without one");

  a_pop_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && busy_q) |-> (advance && cur_last))
    else $error("command replaced before its last byte went out");

  a_last_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cur_last && !q_pop_o) |=> !busy_q)
    else $error("serializer still busy after last byte");

endmodule
